/* rtl/core/assert_macros.svh */
// Assertion macros shared by the ranging distance core.
// Relies on signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the clock, off while reset is high.
`define DSTWR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define DSTWR_ASSERT_IMPL(label, ante, cons, msg) \
   `DSTWR_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define DSTWR_ASSERT_NEXT(label, ante, cons, msg) \
   `DSTWR_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* rtl/core/dstwr_pkg.sv */
// Shared constants and types of the ranging distance core.
// No dependencies.
`default_nettype none

package dstwr_pkg;

   localparam int STAMP_BITS  = 40;
   localparam int SCALE_BITS  = 24;
   localparam int DIST_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DEN_BITS    = STAMP_BITS + 2;
   localparam int HALF_BITS   = (STAMP_BITS + 1) / 2;
   localparam int PROD_BITS   = 2 * STAMP_BITS;
   localparam int PP_LO_BITS  = STAMP_BITS + HALF_BITS;
   localparam int PP_HI_BITS  = PROD_BITS - HALF_BITS;
   localparam int PIECE_BITS  = (PROD_BITS + 3) / 4;
   localparam int MAG_PAD     = 4 * PIECE_BITS;
   localparam int SP_BITS     = PIECE_BITS + SCALE_BITS;
   localparam int NUM_BITS    = PROD_BITS + SCALE_BITS;
   localparam int DIV_BITS    = DEN_BITS + FRAC_BITS;
   localparam int HEAD_BITS   = NUM_BITS - DIST_BITS;
   localparam int NUM_CELLS   = DIST_BITS;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(307386);

   typedef logic [STAMP_BITS-1:0] stamp_type;
   typedef logic [SCALE_BITS-1:0] scale_type;
   typedef logic [DIST_BITS-1:0]  dist_type;

   // Payload handed from one divider cell to the next.
   typedef struct packed {
      logic [DIV_BITS-1:0]  dvsr;   // denominator << FRAC_BITS
      logic [DIV_BITS-1:0]  rem;    // partial remainder, below dvsr unless zero or sat
      logic [DIST_BITS-1:0] dvnd;   // low dividend bits still to shift in
      logic [DIST_BITS-1:0] quo;    // quotient bits so far
      logic                 zero;   // denominator was zero
      logic                 sat;    // quotient does not fit DIST_BITS
   } cell_data_type;

endpackage

`default_nettype wire

/* rtl/core/dstwr_if.sv */
// Request and response channel interfaces of the ranging distance core.
// Depends on dstwr_pkg.
`default_nettype none

interface dstwr_req_if;
   logic                 valid;
   logic                 ready;
   dstwr_pkg::stamp_type poll_sent_time;
   dstwr_pkg::stamp_type poll_heard_time;
   dstwr_pkg::stamp_type reply_sent_time;
   dstwr_pkg::stamp_type reply_heard_time;
   dstwr_pkg::stamp_type last_sent_time;
   dstwr_pkg::stamp_type last_heard_time;

   modport source (
      output valid, poll_sent_time, poll_heard_time, reply_sent_time,
             reply_heard_time, last_sent_time, last_heard_time,
      input  ready
   );
   modport sink (
      input  valid, poll_sent_time, poll_heard_time, reply_sent_time,
             reply_heard_time, last_sent_time, last_heard_time,
      output ready
   );
endinterface

interface dstwr_rsp_if;
   logic                valid;
   logic                ready;
   dstwr_pkg::dist_type distance_mm;
   logic                zero_denominator;
   logic                saturated;

   modport source (
      output valid, distance_mm, zero_denominator, saturated,
      input  ready
   );
   modport sink (
      input  valid, distance_mm, zero_denominator, saturated,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/dstwr_front.sv */
// Front pipeline: durations, products, magnitude, scaling, divider setup.
// Depends on dstwr_pkg and dstwr_if.
`default_nettype none

module dstwr_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   dstwr_req_if.sink                     req,
   input  wire dstwr_pkg::scale_type     scale,
   output dstwr_pkg::cell_data_type      out_data,
   output logic                          out_valid,
   input  wire logic                     out_ready
);

   localparam int STAMP_BITS = dstwr_pkg::STAMP_BITS;
   localparam int DEN_BITS   = dstwr_pkg::DEN_BITS;
   localparam int HALF_BITS  = dstwr_pkg::HALF_BITS;
   localparam int PROD_BITS  = dstwr_pkg::PROD_BITS;
   localparam int PP_LO_BITS = dstwr_pkg::PP_LO_BITS;
   localparam int PP_HI_BITS = dstwr_pkg::PP_HI_BITS;
   localparam int PIECE_BITS = dstwr_pkg::PIECE_BITS;
   localparam int MAG_PAD    = dstwr_pkg::MAG_PAD;
   localparam int SP_BITS    = dstwr_pkg::SP_BITS;
   localparam int NUM_BITS   = dstwr_pkg::NUM_BITS;
   localparam int DIV_BITS   = dstwr_pkg::DIV_BITS;
   localparam int HEAD_BITS  = dstwr_pkg::HEAD_BITS;
   localparam int DIST_BITS  = dstwr_pkg::DIST_BITS;
   localparam int FRAC_BITS  = dstwr_pkg::FRAC_BITS;

   // stage valids and ready ripple
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

   assign rdy7 = !v7_ff || out_ready;
   assign rdy6 = !v6_ff || rdy7;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
         if (rdy7) v7_ff <= v6_ff;
      end
   end

   // stage 1: modular durations and their sum
   dstwr_pkg::stamp_type rt_in, ra_in, rn_in, rp_in;
   dstwr_pkg::stamp_type rt_ff, ra_ff, rn_ff, rp_ff;
   logic [DEN_BITS-1:0]  den_in, den1_ff;

   assign rt_in  = req.reply_heard_time - req.poll_sent_time;
   assign ra_in  = req.reply_sent_time - req.poll_heard_time;
   assign rn_in  = req.last_heard_time - req.reply_sent_time;
   assign rp_in  = req.last_sent_time - req.reply_heard_time;
   assign den_in = DEN_BITS'(rt_in) + DEN_BITS'(ra_in) + DEN_BITS'(rn_in)
                 + DEN_BITS'(rp_in);

   always_ff @(posedge clock) begin
      if (rdy1 && req.valid) begin
         rt_ff   <= rt_in;
         ra_ff   <= ra_in;
         rn_ff   <= rn_in;
         rp_ff   <= rp_in;
         den1_ff <= den_in;
      end
   end

   // stage 2: half-width partial products
   logic [PP_LO_BITS-1:0] pa_lo_in, pa_lo_ff, pb_lo_in, pb_lo_ff;
   logic [PP_HI_BITS-1:0] pa_hi_in, pa_hi_ff, pb_hi_in, pb_hi_ff;
   logic [DEN_BITS-1:0]   den2_ff;

   assign pa_lo_in = PP_LO_BITS'(rt_ff) * PP_LO_BITS'(rn_ff[HALF_BITS-1:0]);
   assign pa_hi_in = PP_HI_BITS'(rt_ff) * PP_HI_BITS'(rn_ff[STAMP_BITS-1:HALF_BITS]);
   assign pb_lo_in = PP_LO_BITS'(rp_ff) * PP_LO_BITS'(ra_ff[HALF_BITS-1:0]);
   assign pb_hi_in = PP_HI_BITS'(rp_ff) * PP_HI_BITS'(ra_ff[STAMP_BITS-1:HALF_BITS]);

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         pa_lo_ff <= pa_lo_in;
         pa_hi_ff <= pa_hi_in;
         pb_lo_ff <= pb_lo_in;
         pb_hi_ff <= pb_hi_in;
         den2_ff  <= den1_ff;
      end
   end

   // stage 3: full products
   logic [PROD_BITS-1:0] pa_in, pa_ff, pb_in, pb_ff;
   logic [DEN_BITS-1:0]  den3_ff;

   assign pa_in = PROD_BITS'(pa_lo_ff) + (PROD_BITS'(pa_hi_ff) << HALF_BITS);
   assign pb_in = PROD_BITS'(pb_lo_ff) + (PROD_BITS'(pb_hi_ff) << HALF_BITS);

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         den3_ff <= den2_ff;
      end
   end

   // stage 4: numerator magnitude
   logic [PROD_BITS-1:0] mag_in, mag_ff;
   logic [DEN_BITS-1:0]  den4_ff;

   assign mag_in = (pa_ff >= pb_ff) ? pa_ff - pb_ff : pb_ff - pa_ff;

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         mag_ff  <= mag_in;
         den4_ff <= den3_ff;
      end
   end

   // stage 5: magnitude pieces times scale
   logic [MAG_PAD-1:0] mag_pad;
   logic [SP_BITS-1:0] sp_in [4];
   logic [SP_BITS-1:0] sp_ff [4];
   logic [DEN_BITS-1:0] den5_ff;

   assign mag_pad = MAG_PAD'(mag_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sp_in[k] = SP_BITS'(mag_pad[k*PIECE_BITS +: PIECE_BITS]) * SP_BITS'(scale);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         for (int k = 0; k < 4; k++) begin
            sp_ff[k] <= sp_in[k];
         end
         den5_ff <= den4_ff;
      end
   end

   // stage 6: scaled numerator
   logic [NUM_BITS-1:0] num_in, num_ff;
   logic [DEN_BITS-1:0] den6_ff;

   always_comb begin
      num_in = '0;
      for (int k = 0; k < 4; k++) begin
         num_in = num_in + (NUM_BITS'(sp_ff[k]) << (k * PIECE_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6 && v5_ff) begin
         num_ff  <= num_in;
         den6_ff <= den5_ff;
      end
   end

   // stage 7: divisor, overflow check on the dividend head, cell seed
   logic [DIV_BITS-1:0]      dvsr;
   logic [HEAD_BITS-1:0]     head;
   logic                     zero, over;
   dstwr_pkg::cell_data_type seed_in, seed_ff;

   assign dvsr = DIV_BITS'(den6_ff) << FRAC_BITS;
   assign head = num_ff[NUM_BITS-1:DIST_BITS];
   assign zero = (den6_ff == '0);
   assign over = (head >= HEAD_BITS'(dvsr));

   always_comb begin
      seed_in.dvsr = dvsr;
      seed_in.rem  = head[DIV_BITS-1:0];
      seed_in.dvnd = num_ff[DIST_BITS-1:0];
      seed_in.quo  = '0;
      seed_in.zero = zero;
      seed_in.sat  = !zero && over;
   end

   always_ff @(posedge clock) begin
      if (rdy7 && v6_ff) begin
         seed_ff <= seed_in;
      end
   end

   assign out_data  = seed_ff;
   assign out_valid = v7_ff;

endmodule

`default_nettype wire

/* rtl/core/dstwr_div_cell.sv */
// One restoring-division cell: retires one quotient bit per pass.
// Depends on dstwr_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dstwr_div_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dstwr_pkg::cell_data_type in_data,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   output dstwr_pkg::cell_data_type      out_data,
   output logic                          out_valid,
   input  wire logic                     out_ready
);

   localparam int DIV_BITS  = dstwr_pkg::DIV_BITS;
   localparam int DIST_BITS = dstwr_pkg::DIST_BITS;

   logic                     out_valid_ff;
   dstwr_pkg::cell_data_type data_in, data_ff;
   logic [DIV_BITS:0]        trial, diff;
   logic                     fits;

   assign in_ready = !out_valid_ff || out_ready;

   assign trial = {in_data.rem, in_data.dvnd[DIST_BITS-1]};
   assign diff  = trial - {1'b0, in_data.dvsr};
   assign fits  = (trial >= {1'b0, in_data.dvsr});

   always_comb begin
      data_in      = in_data;
      data_in.rem  = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      data_in.dvnd = {in_data.dvnd[DIST_BITS-2:0], 1'b0};
      data_in.quo  = {in_data.quo[DIST_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_data  = data_ff;
   assign out_valid = out_valid_ff;

   `DSTWR_ASSERT_IMPL(a_rem_below_dvsr,
      out_valid_ff && !data_ff.zero && !data_ff.sat,
      data_ff.rem < data_ff.dvsr, "partial remainder not below divisor")
   `DSTWR_ASSERT_NEXT(a_take_then_hold, in_valid && in_ready, out_valid_ff,
      "cell took a request but shows no result")

endmodule

`default_nettype wire

/* rtl/core/ds_twr_distance_core.sv */
// Top level of the double-sided two-way ranging distance core.
// Depends on dstwr_pkg, dstwr_if, dstwr_front, dstwr_div_cell, assert_macros.svh.
//
//   port      dir    handshake        carries
//   req_chan  in     valid/ready      six 40-bit exchange timestamps
//   rsp_chan  out    valid/ready      distance_mm, zero_denominator, saturated
//   csr_*     in     csr_we strobe    24-bit Q16 mm-per-tick scale
//
// Takes one request per cycle unless back-pressure from rsp_chan stalls it; 40
// register stages (7 front stages, one cell per quotient bit (32), one output
// register) lie between a request and its result.
// Every stage holds its own valid bit; a stage takes new data whenever it is
// empty or its neighbor takes its data, so bubbles close up under stalls.
// Reset (synchronous) empties the pipeline and reloads the scale register.
`default_nettype none

`include "assert_macros.svh"

module ds_twr_distance_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dstwr_req_if.sink                 req_chan,
   dstwr_rsp_if.source               rsp_chan,
   input  wire logic                 csr_we,
   input  wire dstwr_pkg::scale_type csr_wdata
);

   localparam int NUM_CELLS = dstwr_pkg::NUM_CELLS;

   // scale register; the user must write it only while the core is idle (not enforced)
   dstwr_pkg::scale_type csr_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_scale_ff <= dstwr_pkg::SCALE_RESET;
      end else if (csr_we) begin
         csr_scale_ff <= csr_wdata;
      end
   end

   // link k feeds cell k; link NUM_CELLS feeds the output register
   dstwr_pkg::cell_data_type link_data  [NUM_CELLS+1];
   logic                     link_valid [NUM_CELLS+1];
   logic                     link_ready [NUM_CELLS+1];

   dstwr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .scale     (csr_scale_ff),
      .out_data  (link_data[0]),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0])
   );

   // chain of division cells, MSB of the quotient first
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      dstwr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_data   (link_data[k]),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .out_data  (link_data[k+1]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1])
      );
   end

   // output register; zero denominator wins over overflow
   logic                rsp_valid_ff;
   dstwr_pkg::dist_type dist_in, dist_ff;
   logic                zero_ff, sat_ff;
   logic                tail_take;

   assign link_ready[NUM_CELLS] = !rsp_valid_ff || rsp_chan.ready;
   assign tail_take = link_valid[NUM_CELLS] && link_ready[NUM_CELLS];

   always_comb begin
      priority if (link_data[NUM_CELLS].zero) begin
         dist_in = '0;
      end else if (link_data[NUM_CELLS].sat) begin
         dist_in = '1;
      end else begin
         dist_in = link_data[NUM_CELLS].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (link_ready[NUM_CELLS]) begin
         rsp_valid_ff <= link_valid[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (tail_take) begin
         dist_ff <= dist_in;
         zero_ff <= link_data[NUM_CELLS].zero;
         sat_ff  <= link_data[NUM_CELLS].sat;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.distance_mm      = dist_ff;
   assign rsp_chan.zero_denominator = zero_ff;
   assign rsp_chan.saturated        = sat_ff;

   `DSTWR_ASSERT_IMPL(a_flags_exclusive, rsp_valid_ff, !(zero_ff && sat_ff),
      "zero denominator and saturation both flagged")
   `DSTWR_ASSERT_NEXT(a_tail_lands, tail_take, rsp_valid_ff,
      "last cell handed off a result that did not land")

endmodule

`default_nettype wire
